// File: sv/dsm_pkg.sv
// Shared types and constants for the three-axis deadband smoother.
package dsm_pkg;

    localparam int NUM_AXES = 3;

    localparam logic signed [16:0] WRAP_POS = 17'sd30720;
    localparam logic signed [16:0] WRAP_NEG = -17'sd30720;
    localparam logic [16:0]        ALPHA_ONE = 17'd65536;

    localparam logic [16:0] ALPHA_RESET    = 17'd3277;
    localparam logic [15:0] DEADBAND_RESET = 16'd512;

    localparam logic [2:0] REG_ALPHA_ROLL     = 3'd0;
    localparam logic [2:0] REG_ALPHA_PITCH    = 3'd1;
    localparam logic [2:0] REG_ALPHA_YAW      = 3'd2;
    localparam logic [2:0] REG_DEADBAND_ROLL  = 3'd3;
    localparam logic [2:0] REG_DEADBAND_PITCH = 3'd4;
    localparam logic [2:0] REG_DEADBAND_YAW   = 3'd5;

    localparam logic signed [34:0] ROLL_OFFSET = 35'sd419430400;
    localparam logic signed [34:0] WIDE_OFFSET = 35'sd1509949440;
    localparam logic [31:0]        ROLL_LIMIT  = 32'd318767104;
    localparam logic [31:0]        WIDE_LIMIT  = 32'd3019898880;
    localparam logic [9:0]         ROLL_MUL    = 10'd1000;
    localparam logic [9:0]         WIDE_MUL    = 10'd100;
    localparam logic [16:0]        ROLL_RECIP  = 17'd55188;
    localparam logic [16:0]        WIDE_RECIP  = 17'd116508;
    localparam logic [4:0]         ROLL_DIV    = 5'd19;
    localparam logic [4:0]         WIDE_DIV    = 5'd9;
    localparam logic [11:0]        PULSE_BASE  = 12'd500;

    typedef enum logic { MAP_ROLL = 1'b0, MAP_WIDE = 1'b1 } map_kind_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][16:0] alpha;
        logic [NUM_AXES-1:0][15:0] deadband;
    } cfg_t;

    typedef struct packed {
        logic guard;
        logic mul_lo;
        logic mul_hi;
        logic acc;
        logic clamp;
        logic scale;
        logic recip;
        logic fix;
    } lane_ctrl_t;

endpackage

// File: sv/three_axis_deadband_smoother_to_pwm_core.sv
// Top level: stream ports, step sequencer, three axis lanes and output merge.
//
// Usage: each transfer on the s_axis channel carries one roll/pitch/yaw sample
// in signed Q9.8 degrees; each transfer on the m_axis channel carries the three
// servo pulse widths in microseconds, one result per sample, in order.
// Smoothing factors and deadbands sit in six registers on the APB-style port
// (byte address 4*i); write them only while no sample is in flight.
// The three lanes run side by side, one per axis, stepped by a shared
// sequencer; the output register merges the lane results into one transfer.
// Flow: the sequencer walks guard, two partial products, accumulate, clamp,
// scale, reciprocal and correction steps, one registered step per cycle in each
// lane; a new sample is accepted only after the previous one has left the lanes.
// A finished result waits in the output register, so the next sample is taken
// while the previous transfer is still pending. If the receiver stalls, the
// next result waits in the lanes and s_axis_tready stays low until it moves on.
// Reset: held targets and smoothed angles clear to zero, the registers take
// their defaults (alpha 3277, deadband 512), and both channels go idle.
module three_axis_deadband_smoother_to_pwm_core
    import dsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // roll_in [16:0], pitch_in [33:17], yaw_in [50:34], zero [55:51]
    input  logic [55:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // gripper_pulse_us [10:0], elevation_pulse_us [22:11], turn_pulse_us [34:23],
    // zero [39:35]
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b0_0000_0001,
        ST_MUL_LO = 9'b0_0000_0010,
        ST_MUL_HI = 9'b0_0000_0100,
        ST_ACC    = 9'b0_0000_1000,
        ST_CLAMP  = 9'b0_0001_0000,
        ST_SCALE  = 9'b0_0010_0000,
        ST_RECIP  = 9'b0_0100_0000,
        ST_FIX    = 9'b0_1000_0000,
        ST_DONE   = 9'b1_0000_0000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [39:0] out_data_reg;

    cfg_t        cfg;
    lane_ctrl_t  ctrl;
    logic        accept;
    logic        load;
    logic [11:0] pulse_roll;
    logic [11:0] pulse_pitch;
    logic [11:0] pulse_yaw;

    dsm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load          = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        ctrl.guard  = accept;
        ctrl.mul_lo = (state_reg == ST_MUL_LO);
        ctrl.mul_hi = (state_reg == ST_MUL_HI);
        ctrl.acc    = (state_reg == ST_ACC);
        ctrl.clamp  = (state_reg == ST_CLAMP);
        ctrl.scale  = (state_reg == ST_SCALE);
        ctrl.recip  = (state_reg == ST_RECIP);
        ctrl.fix    = (state_reg == ST_FIX);
    end

    dsm_lane #(.MAP(MAP_ROLL)) u_lane_roll (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .angle    (s_axis_tdata[16:0]),
        .alpha    (cfg.alpha[0]),
        .deadband (cfg.deadband[0]),
        .pulse_us (pulse_roll)
    );

    dsm_lane #(.MAP(MAP_WIDE)) u_lane_pitch (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .angle    (s_axis_tdata[33:17]),
        .alpha    (cfg.alpha[1]),
        .deadband (cfg.deadband[1]),
        .pulse_us (pulse_pitch)
    );

    dsm_lane #(.MAP(MAP_WIDE)) u_lane_yaw (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .angle    (s_axis_tdata[50:34]),
        .alpha    (cfg.alpha[2]),
        .deadband (cfg.deadband[2]),
        .pulse_us (pulse_yaw)
    );

    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = accept ? ST_MUL_LO : ST_IDLE;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_ACC;
            ST_ACC:    state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_RECIP;
            ST_RECIP:  state_next = ST_FIX;
            ST_FIX:    state_next = ST_DONE;
            ST_DONE:   state_next = load ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // merge lane results into one transfer
    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= {5'd0, pulse_yaw, pulse_pitch, pulse_roll[10:0]};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MUL_LO))
        else $error("accepted sample did not start the lane sequence");

    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state lost its one-hot code");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result presented without a finished lane sequence");

    a_gripper_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:0] >= 11'd500 && m_axis_tdata[10:0] <= 11'd1500))
        else $error("gripper pulse out of range");

    a_elevation_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[22:11] >= 12'd500 && m_axis_tdata[22:11] <= 12'd2500))
        else $error("elevation pulse out of range");

endmodule

// File: sv/dsm_regs.sv
// Configuration register file behind the APB-style port.
module dsm_regs
    import dsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ALPHA_ROLL:     cfg_next.alpha[0]    = pwdata[16:0];
                REG_ALPHA_PITCH:    cfg_next.alpha[1]    = pwdata[16:0];
                REG_ALPHA_YAW:      cfg_next.alpha[2]    = pwdata[16:0];
                REG_DEADBAND_ROLL:  cfg_next.deadband[0] = pwdata[15:0];
                REG_DEADBAND_PITCH: cfg_next.deadband[1] = pwdata[15:0];
                REG_DEADBAND_YAW:   cfg_next.deadband[2] = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ALPHA_ROLL:     prdata = {15'd0, cfg_reg.alpha[0]};
            REG_ALPHA_PITCH:    prdata = {15'd0, cfg_reg.alpha[1]};
            REG_ALPHA_YAW:      prdata = {15'd0, cfg_reg.alpha[2]};
            REG_DEADBAND_ROLL:  prdata = {16'd0, cfg_reg.deadband[0]};
            REG_DEADBAND_PITCH: prdata = {16'd0, cfg_reg.deadband[1]};
            REG_DEADBAND_YAW:   prdata = {16'd0, cfg_reg.deadband[2]};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                cfg_reg.alpha[k]    <= ALPHA_RESET;
                cfg_reg.deadband[k] <= DEADBAND_RESET;
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/dsm_lane.sv
// One axis lane: wrap guard, deadband hold, moving average and pulse map.
module dsm_lane
    import dsm_pkg::*;
#(
    parameter map_kind_t MAP = MAP_WIDE
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lane_ctrl_t         ctrl,
    input  logic signed [16:0] angle,
    input  logic [16:0]        alpha,
    input  logic [15:0]        deadband,
    output logic [11:0]        pulse_us
);

    localparam logic signed [34:0] OFFSET = (MAP == MAP_ROLL) ? ROLL_OFFSET : WIDE_OFFSET;
    localparam logic [31:0]        LIMIT  = (MAP == MAP_ROLL) ? ROLL_LIMIT  : WIDE_LIMIT;
    localparam logic [9:0]         MUL    = (MAP == MAP_ROLL) ? ROLL_MUL    : WIDE_MUL;
    localparam logic [16:0]        RECIP  = (MAP == MAP_ROLL) ? ROLL_RECIP  : WIDE_RECIP;
    localparam logic [4:0]         DIV    = (MAP == MAP_ROLL) ? ROLL_DIV    : WIDE_DIV;

    logic signed [15:0] held_reg;
    logic signed [15:0] held_next;
    logic signed [33:0] smooth_reg;
    logic signed [33:0] smooth_next;
    logic signed [34:0] diff_reg;
    logic signed [34:0] diff_next;
    logic [33:0]        p_lo_reg;
    logic signed [35:0] p_hi_reg;
    logic [31:0]        vc_reg;
    logic [14:0]        t_reg;
    logic [11:0]        qe_reg;
    logic [11:0]        pulse_reg;

    logic               wrap;
    logic signed [16:0] x_g;
    logic signed [17:0] d;
    logic [17:0]        d_abs;
    logic [16:0]        a_sat;
    logic signed [17:0] a_s;
    logic signed [17:0] dh_s;
    logic signed [52:0] total;
    logic signed [34:0] v;
    logic [31:0]        vc_next;
    logic [41:0]        prod;
    logic [31:0]        rp;
    logic [16:0]        qd;
    logic [16:0]        r;
    logic [11:0]        q;

    assign wrap  = (angle > WRAP_POS) || (angle < WRAP_NEG);
    assign x_g   = wrap ? {held_reg[15], held_reg} : angle;
    assign d     = {x_g[16], x_g} - {{2{held_reg[15]}}, held_reg};
    assign d_abs = d[17] ? 18'(-d) : d;

    always_comb
    begin
        held_next = held_reg;
        if (d_abs > {2'b00, deadband})
            held_next = x_g[15:0];
    end

    assign diff_next = {{3{held_next[15]}}, held_next, 16'd0} - {smooth_reg[33], smooth_reg};

    assign a_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
    assign a_s   = {1'b0, a_sat};
    assign dh_s  = diff_reg[34:17];

    assign total       = {p_hi_reg, 17'd0} + {19'd0, p_lo_reg};
    assign smooth_next = smooth_reg + total[49:16];

    assign v = {smooth_reg[33], smooth_reg} + OFFSET;

    always_comb
    begin
        if (v[34])
            vc_next = 32'd0;
        else if (v > $signed({3'b000, LIMIT}))
            vc_next = LIMIT;
        else
            vc_next = v[31:0];
    end

    assign prod = 42'(vc_reg) * 42'(MUL);
    assign rp   = 32'(t_reg) * 32'(RECIP);
    assign qd   = 17'(qe_reg) * 17'(DIV);
    assign r    = {2'b00, t_reg} - qd;
    assign q    = (r >= 17'(DIV)) ? 12'(qe_reg + 12'd1) : qe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            smooth_reg <= '0;
        end
        else
        begin
            if (ctrl.guard)
                held_reg <= held_next;
            if (ctrl.acc)
                smooth_reg <= smooth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.guard)
            diff_reg <= diff_next;
        if (ctrl.mul_lo)
            p_lo_reg <= 34'(a_sat) * 34'(diff_reg[16:0]);
        if (ctrl.mul_hi)
            p_hi_reg <= a_s * dh_s;
        if (ctrl.clamp)
            vc_reg <= vc_next;
        if (ctrl.scale)
            t_reg <= prod[38:24];
        if (ctrl.recip)
            qe_reg <= rp[31:20];
        if (ctrl.fix)
            pulse_reg <= q + PULSE_BASE;
    end

    assign pulse_us = pulse_reg;

endmodule
